>>> rtl/core/tcp_flow_counter_table_defines.svh
// ----------------------------------------------------------------------------
// Flow counter table assertion macros
// Concurrent assertion wrappers shared by the flow table RTL.
// ----------------------------------------------------------------------------
`ifndef TCP_FLOW_COUNTER_TABLE_DEFINES_SVH
`define TCP_FLOW_COUNTER_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ftc_pkg.sv
// ----------------------------------------------------------------------------
// Flow counter table package
// Shared types and constants of the flow table.
// ----------------------------------------------------------------------------
package ftc_pkg;

  localparam int CNT_W = 32;
  localparam int LEN_W = 17;
  localparam int IDX_OUT_W = 6;

  typedef struct packed {
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } key_t;

  typedef struct packed {
    key_t             key;
    logic [CNT_W-1:0] pkts;
    logic [CNT_W-1:0] bytes;
  } entry_t;

  typedef enum logic [1:0] {
    STATUS_UPDATED = 2'd0,
    STATUS_NEW     = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

endpackage

>>> rtl/core/tcp_flow_counter_table.sv
// ----------------------------------------------------------------------------
// TCP flow packet and byte counter table
// Looks up a packet's flow key in a table, counts packets and bytes per flow.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  in_*      slave      one packet: flow key and length
//  out_*     master     one result: status, slot, packet and byte counts
//
// A new flow is accepted, every stored key is read and compared, the shared
// saturating adder adds the packet count and then the byte count, and the
// output register is loaded. A hit ends the search at its slot, and a drop from
// a full table goes from the search straight to the output register.
// Reset clears only the fill count and the control state; unfilled slots are
// never read. A stalled output holds its result while the next packet is
// searched; the block waits in its last step only until the output frees.
//
`include "tcp_flow_counter_table_defines.svh"

module tcp_flow_counter_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input: src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80],
  // packet_length[112:96], zero fill [119:113].
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,
  // Output: status[1:0], entry_index[7:2], flow_packets[39:8],
  // flow_bytes[71:40].
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata
);
  import ftc_pkg::*;

  // Slot index width and a counter width that can hold the depth itself.
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADD_PKT,
    S_ADD_BYTE,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  key_t              key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CW-1:0]     issue_r, issue_nxt;     // next slot to read
  logic              pend_r, pend_nxt;       // a read is returning this cycle
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt; // slot of the returning read
  logic [CW-1:0]     used_r, used_nxt;       // fill count; slots fill from 0
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]  pkt_r, pkt_nxt;
  logic [CNT_W-1:0]  byte_r, byte_nxt;
  status_t           status_r, status_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [71:0]       out_tdata_r, out_tdata_nxt;

  logic              rd_en;
  logic              wr_en;
  logic [EW-1:0]     rd_raw;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              hit;
  logic              table_full;
  logic              out_drop;
  logic [CNT_W-1:0]  add_a, add_b, add_sum;

  // Table of keys and counters. A hit rewrites the whole entry with the same key.
  ftc_ram #(
    .WIDTH  (EW),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_r),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (issue_r[IW-1:0]),
    .rdata (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  // The single adder serves the packet count first, then the byte count.
  assign add_a = (state_r == S_ADD_PKT) ? pkt_r : byte_r;
  assign add_b = (state_r == S_ADD_PKT) ? CNT_W'(1) : CNT_W'(len_r);

  ftc_sat_add u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  assign hit        = (state_r == S_SCAN) && pend_r && (rd_entry.key == key_r);
  assign table_full = (used_r == CW'(TABLE_DEPTH));
  assign rd_en      = (state_r == S_SCAN) && !hit && (issue_r != used_r);
  assign wr_en      = (state_r == S_ADD_BYTE);
  assign out_drop   = out_tvalid_r && (out_tdata_r[1:0] == STATUS_DROPPED);

  always_comb begin
    wr_entry.key   = key_r;
    wr_entry.pkts  = pkt_r;
    wr_entry.bytes = add_sum;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    cmp_idx_nxt    = cmp_idx_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    pkt_nxt        = pkt_r;
    byte_nxt       = byte_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    // A waiting result leaves as soon as the sink takes it.
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt.src_addr = in_tdata[31:0];
          key_nxt.dst_addr = in_tdata[63:32];
          key_nxt.src_port = in_tdata[79:64];
          key_nxt.dst_port = in_tdata[95:80];
          len_nxt          = in_tdata[112:96];
          issue_nxt        = '0;
          pend_nxt         = 1'b0;
          state_nxt        = S_SCAN;
        end
      end

      S_SCAN: begin
        // Reads are issued back to back; each returning key is compared
        // while the next read is in flight.
        pend_nxt = rd_en;
        if (rd_en) begin
          issue_nxt   = issue_r + CW'(1);
          cmp_idx_nxt = issue_r[IW-1:0];
        end
        if (hit) begin
          idx_nxt    = cmp_idx_r;
          pkt_nxt    = rd_entry.pkts;
          byte_nxt   = rd_entry.bytes;
          status_nxt = STATUS_UPDATED;
          state_nxt  = S_ADD_PKT;
        end else if (!pend_r && (issue_r == used_r)) begin
          // Every stored flow has been checked without a match.
          idx_nxt  = '0;
          pkt_nxt  = '0;
          byte_nxt = '0;
          if (table_full) begin
            status_nxt = STATUS_DROPPED;
            state_nxt  = S_EMIT;
          end else begin
            idx_nxt    = used_r[IW-1:0];
            status_nxt = STATUS_NEW;
            state_nxt  = S_ADD_PKT;
          end
        end
      end

      S_ADD_PKT: begin
        pkt_nxt   = add_sum;
        state_nxt = S_ADD_BYTE;
      end

      S_ADD_BYTE: begin
        // The entry is written back this cycle with the new byte count.
        byte_nxt = add_sum;
        if (status_r == STATUS_NEW) begin
          used_nxt = used_r + CW'(1);
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {byte_r, pkt_r, IDX_OUT_W'(idx_r), status_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= 1'b0;
      used_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      used_r       <= used_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    key_r       <= key_nxt;
    len_r       <= len_nxt;
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    idx_r       <= idx_nxt;
    pkt_r       <= pkt_nxt;
    byte_r      <= byte_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // The fill count never runs past the table depth.
  `FTC_ASSERT_NOW(a_used_bound, clk, rst_n, 1'b1, used_r <= CW'(TABLE_DEPTH), "fill overrun")
  // A match can only come from a slot that has been filled.
  `FTC_ASSERT_NOW(a_hit_filled, clk, rst_n, hit, CW'(cmp_idx_r) < used_r, "hit on empty slot")
  // A drop is only reported when the table is full.
  `FTC_ASSERT_NOW(a_drop_full, clk, rst_n, out_drop, table_full, "drop with free slots")
  // After an accepted transfer the block is busy on the next cycle.
  `FTC_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready while busy")

endmodule

>>> rtl/core/ftc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ftc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ftc_sat_add.sv
// ----------------------------------------------------------------------------
// Saturating counter adder
// Shared 32-bit adder that clamps at the all-ones value on overflow.
// ----------------------------------------------------------------------------
module ftc_sat_add (
  input  logic [ftc_pkg::CNT_W-1:0] a,
  input  logic [ftc_pkg::CNT_W-1:0] b,
  output logic [ftc_pkg::CNT_W-1:0] sum
);
  import ftc_pkg::*;

  logic [CNT_W:0] raw;

  assign raw = {1'b0, a} + {1'b0, b};
  assign sum = raw[CNT_W] ? {CNT_W{1'b1}} : raw[CNT_W-1:0];

endmodule
